FILE: rtl/date_string_validator_assert.svh
// Assertion macros for the date string validator.
// Used by date_string_validator.sv; needs a clock named aclk and a reset named aresetn.
`ifndef DATE_STRING_VALIDATOR_ASSERT_SVH
`define DATE_STRING_VALIDATOR_ASSERT_SVH

// Checked on every rising edge while the block is out of reset.
`define DSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/dsv_pkg.sv
// Shared types and constants for the date string validator.
// No dependencies; used by dsv_verdict, dsv_step and date_string_validator.
`default_nettype none

package dsv_pkg;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] DM_DIGITS_MAX   = 3'd2;
    localparam logic [2:0] YEAR_DIGITS_MAX = 3'd4;
    localparam logic [2:0] YEAR_DIGITS_SHORT = 3'd2;
    localparam logic [2:0] COUNT_SAT       = 3'd7;

    localparam logic [13:0] YEAR_OFFSET       = 14'd2000;
    localparam logic [3:0]  OFFSET_THOUSANDS  = 4'd2;

    localparam logic [6:0] MONTH_FIRST = 7'd1;
    localparam logic [6:0] MONTH_LAST  = 7'd12;
    localparam logic [6:0] MONTH_FEB   = 7'd2;
    localparam logic [6:0] MONTH_APR   = 7'd4;
    localparam logic [6:0] MONTH_JUN   = 7'd6;
    localparam logic [6:0] MONTH_SEP   = 7'd9;
    localparam logic [6:0] MONTH_NOV   = 7'd11;
    localparam logic [6:0] DAY_FIRST   = 7'd1;

    localparam logic [6:0] DAYS_FEB_LEAP = 7'd29;
    localparam logic [6:0] DAYS_FEB      = 7'd28;
    localparam logic [6:0] DAYS_SHORT    = 7'd30;
    localparam logic [6:0] DAYS_LONG     = 7'd31;

    typedef enum logic [1:0] {
        FIELD_DAY   = 2'd0,
        FIELD_MONTH = 2'd1,
        FIELD_YEAR  = 2'd2
    } field_t;

    // year_digits keeps the decimal digits of the year, ones in [0], so the
    // leap rule needs no division.
    typedef struct packed {
        field_t          field_pos;
        logic [2:0]      digit_count;
        logic [6:0]      day;
        logic [6:0]      month;
        logic [13:0]     year;
        logic [3:0][3:0] year_digits;
        logic            bad;
        logic            done;
    } parse_state_t;

    typedef struct packed {
        logic [13:0] year_number;
        logic [6:0]  month_number;
        logic [6:0]  day_number;
        logic        date_valid;
    } result_t;

    localparam parse_state_t STATE_RESET = '0;

endpackage

`default_nettype wire

FILE: rtl/dsv_verdict.sv
// Calendar check of a fully parsed date: month range, days in month, leap rule.
// Depends on dsv_pkg.
`default_nettype none

module dsv_verdict (
    input  var dsv_pkg::parse_state_t st,
    output logic                      date_valid
);

    logic [1:0] year_mod4;
    logic [1:0] cent_mod4;
    logic       cent_zero;
    logic       leap;
    logic [6:0] month_len;

    // y mod 4 = (2*tens + ones) mod 4, and y/100 mod 4 = (2*thousands + hundreds) mod 4.
    assign year_mod4 = {st.year_digits[1][0], 1'b0} + st.year_digits[0][1:0];
    assign cent_mod4 = {st.year_digits[3][0], 1'b0} + st.year_digits[2][1:0];
    assign cent_zero = (st.year_digits[1] == 4'd0) && (st.year_digits[0] == 4'd0);
    assign leap = ((year_mod4 == 2'd0) && !cent_zero) || (cent_zero && (cent_mod4 == 2'd0));

    always_comb begin
        case (st.month)
            dsv_pkg::MONTH_FEB: begin
                month_len = leap ? dsv_pkg::DAYS_FEB_LEAP : dsv_pkg::DAYS_FEB;
            end
            dsv_pkg::MONTH_APR, dsv_pkg::MONTH_JUN, dsv_pkg::MONTH_SEP,
            dsv_pkg::MONTH_NOV: begin
                month_len = dsv_pkg::DAYS_SHORT;
            end
            default: begin
                month_len = dsv_pkg::DAYS_LONG;
            end
        endcase
    end

    assign date_valid = !st.bad && st.done &&
                        (st.month >= dsv_pkg::MONTH_FIRST) &&
                        (st.month <= dsv_pkg::MONTH_LAST) &&
                        (st.day >= dsv_pkg::DAY_FIRST) &&
                        (st.day <= month_len);

endmodule

`default_nettype wire

FILE: rtl/dsv_step.sv
// Per-character parser update and end-of-string result for the date validator.
// Depends on dsv_pkg and dsv_verdict.
`default_nettype none

module dsv_step (
    input  var dsv_pkg::parse_state_t st,
    input  logic [7:0]                char_code,
    input  logic                      last_char,
    output dsv_pkg::parse_state_t     st_next,
    output dsv_pkg::result_t          result
);

    function automatic dsv_pkg::parse_state_t close_field(input dsv_pkg::parse_state_t s);
        dsv_pkg::parse_state_t r;
        r = s;
        case (s.field_pos)
            dsv_pkg::FIELD_DAY: begin
                if (s.digit_count < 3'd1 || s.digit_count > dsv_pkg::DM_DIGITS_MAX) begin
                    r.bad = 1'b1;
                end
                r.field_pos = dsv_pkg::FIELD_MONTH;
            end
            dsv_pkg::FIELD_MONTH: begin
                if (s.digit_count < 3'd1 || s.digit_count > dsv_pkg::DM_DIGITS_MAX) begin
                    r.bad = 1'b1;
                end
                r.field_pos = dsv_pkg::FIELD_YEAR;
            end
            dsv_pkg::FIELD_YEAR: begin
                if (s.digit_count != dsv_pkg::YEAR_DIGITS_SHORT &&
                    s.digit_count != dsv_pkg::YEAR_DIGITS_MAX) begin
                    r.bad = 1'b1;
                end
                // A two-digit year lands in the 2000s; the hundreds digit is already zero.
                if (s.digit_count == dsv_pkg::YEAR_DIGITS_SHORT) begin
                    r.year = s.year + dsv_pkg::YEAR_OFFSET;
                    r.year_digits[3] = dsv_pkg::OFFSET_THOUSANDS;
                end
                r.done = 1'b1;
            end
            default: begin
                r = s;
            end
        endcase
        r.digit_count = 3'd0;
        return r;
    endfunction

    function automatic dsv_pkg::parse_state_t take_digit(input dsv_pkg::parse_state_t s,
                                                          input logic [3:0] d);
        dsv_pkg::parse_state_t r;
        logic [2:0]            limit;
        r = s;
        limit = (s.field_pos == dsv_pkg::FIELD_YEAR) ? dsv_pkg::YEAR_DIGITS_MAX
                                                      : dsv_pkg::DM_DIGITS_MAX;
        // Digits past the field's limit are counted but not accumulated.
        if (s.digit_count < limit) begin
            case (s.field_pos)
                dsv_pkg::FIELD_DAY: begin
                    r.day = {s.day[3:0], 3'b000} + {s.day[5:0], 1'b0} + {3'b000, d};
                end
                dsv_pkg::FIELD_MONTH: begin
                    r.month = {s.month[3:0], 3'b000} + {s.month[5:0], 1'b0} + {3'b000, d};
                end
                default: begin
                    r.year = {s.year[10:0], 3'b000} + {s.year[12:0], 1'b0} + {10'd0, d};
                    r.year_digits = {s.year_digits[2:0], d};
                end
            endcase
        end
        if (s.digit_count < dsv_pkg::COUNT_SAT) begin
            r.digit_count = s.digit_count + 3'd1;
        end
        if (r.digit_count > dsv_pkg::YEAR_DIGITS_MAX) begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    logic [3:0]            digit_offset;
    logic                  is_digit;
    dsv_pkg::parse_state_t st_char;
    dsv_pkg::parse_state_t st_end;
    logic                  verdict;

    assign digit_offset = 4'(char_code - dsv_pkg::CHAR_ZERO);
    assign is_digit = (char_code >= dsv_pkg::CHAR_ZERO) && (char_code <= dsv_pkg::CHAR_NINE);

    always_comb begin
        st_char = st;
        if (!st.done) begin
            if (char_code == dsv_pkg::CHAR_SLASH) begin
                st_char = close_field(st);
            end else if (is_digit) begin
                st_char = take_digit(st, digit_offset);
            end else begin
                st_char.bad = 1'b1;
            end
        end
    end

    // The end of the string closes an open year field; anywhere else it is too early.
    always_comb begin
        st_end = st_char;
        if (!st_char.done) begin
            if (st_char.field_pos == dsv_pkg::FIELD_YEAR) begin
                st_end = close_field(st_char);
            end else begin
                st_end.bad = 1'b1;
            end
        end
    end

    dsv_verdict u_verdict (
        .st         (st_end),
        .date_valid (verdict)
    );

    assign result.date_valid   = verdict;
    assign result.day_number   = st_end.day;
    assign result.month_number = st_end.month;
    assign result.year_number  = st_end.year;

    assign st_next = last_char ? dsv_pkg::STATE_RESET : st_char;

endmodule

`default_nettype wire

FILE: rtl/date_string_validator.sv
// Date string validator: takes a day/month/year ASCII string one byte per item
// on the s_ stream (s_tlast on the final byte) and gives one verdict item on the
// m_ stream per string. It accepts one byte every clock cycle; a byte is held in
// an input register, from which the parser state register updates; on the final
// byte the combinational calendar check result is loaded into an output register,
// which drives m_tvalid. The parser state register is the only thing that carries
// from byte to byte. Only a final byte waits when an earlier verdict has not yet
// been taken, and the bytes behind it wait with it.
// Depends on dsv_pkg, dsv_step and date_string_validator_assert.svh.
`default_nettype none

module date_string_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] date_valid, [7:1] day_number,
                                   // [14:8] month_number, [28:15] year_number, rest zero
);

    `include "date_string_validator_assert.svh"

    logic                  in_vld_reg;
    logic [7:0]            in_char_reg;
    logic                  in_last_reg;
    dsv_pkg::parse_state_t state_reg;
    dsv_pkg::parse_state_t state_next;
    dsv_pkg::result_t      step_result;
    logic                  out_vld_reg;
    dsv_pkg::result_t      out_reg;
    logic                  out_free;
    logic                  proc_go;
    logic                  final_go;
    logic                  state_idle;
    logic                  year_seen;
    logic                  in_year_field;

    assign out_free = !out_vld_reg || m_tready;
    assign proc_go  = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dsv_step u_step (
        .st        (state_reg),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .st_next   (state_next),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsv_pkg::STATE_RESET;
        end else if (proc_go) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc_go && in_last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && in_last_reg) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.year_number, out_reg.month_number,
                       out_reg.day_number, out_reg.date_valid};

    assign final_go      = proc_go && in_last_reg;
    assign state_idle    = (state_reg == dsv_pkg::STATE_RESET);
    assign year_seen     = (state_reg.year != 14'd0);
    assign in_year_field = (state_reg.field_pos == dsv_pkg::FIELD_YEAR);

    `DSV_ASSERT(a_verdict_loaded, final_go |=> out_vld_reg, "verdict not registered")
    `DSV_ASSERT(a_state_cleared, final_go |=> state_idle, "parser not cleared after final byte")
    `DSV_ASSERT(a_year_in_field, year_seen |-> in_year_field, "year outside its field")
    `DSV_ASSERT(a_nonlast_flows, in_vld_reg && !in_last_reg |-> s_tready, "non-final byte stalled")
    `DSV_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !out_vld_reg && !in_vld_reg, "busy after reset")

endmodule

`default_nettype wire

FILE: bench/dsv_checker.sv
// Checker for the date string validator: watches both streams, predicts each verdict
// from the accepted bytes and compares it field by field. Depends on dsv_pkg.
`timescale 1ns / 100ps

module dsv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          verdicts_pending
);

    typedef struct packed {
        logic        ok;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
    } verdict_t;

    verdict_t         verdict_q[$];
    dsv_pkg::field_t  field_pos;
    logic [2:0]       digit_cnt;
    logic [6:0]       day_acc;
    logic [6:0]       month_acc;
    logic [13:0]      year_acc;
    logic             bad;
    logic             done;
    int               fails = 0;

    assign fail_count = fails;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        if (m == dsv_pkg::MONTH_FEB)
            return leap_year(y) ? dsv_pkg::DAYS_FEB_LEAP : dsv_pkg::DAYS_FEB;
        if (m == dsv_pkg::MONTH_APR || m == dsv_pkg::MONTH_JUN || m == dsv_pkg::MONTH_SEP ||
            m == dsv_pkg::MONTH_NOV)
            return dsv_pkg::DAYS_SHORT;
        return dsv_pkg::DAYS_LONG;
    endfunction

    task automatic clear_parse();
        field_pos = dsv_pkg::FIELD_DAY;
        digit_cnt = '0;
        day_acc   = '0;
        month_acc = '0;
        year_acc  = '0;
        bad       = 1'b0;
        done      = 1'b0;
    endtask

    task automatic close_field();
        case (field_pos)
            dsv_pkg::FIELD_DAY: begin
                if (digit_cnt < 1 || digit_cnt > dsv_pkg::DM_DIGITS_MAX)
                    bad = 1'b1;
                field_pos = dsv_pkg::FIELD_MONTH;
            end
            dsv_pkg::FIELD_MONTH: begin
                if (digit_cnt < 1 || digit_cnt > dsv_pkg::DM_DIGITS_MAX)
                    bad = 1'b1;
                field_pos = dsv_pkg::FIELD_YEAR;
            end
            default: begin
                if (digit_cnt != dsv_pkg::YEAR_DIGITS_SHORT &&
                    digit_cnt != dsv_pkg::YEAR_DIGITS_MAX)
                    bad = 1'b1;
                if (digit_cnt == dsv_pkg::YEAR_DIGITS_SHORT)
                    year_acc = year_acc + dsv_pkg::YEAR_OFFSET;
                done = 1'b1;
            end
        endcase
        digit_cnt = '0;
    endtask

    // Digits past the field's width are counted but not accumulated.
    task automatic take_digit(input logic [3:0] d);
        int keep;
        keep = (field_pos == dsv_pkg::FIELD_YEAR) ? dsv_pkg::YEAR_DIGITS_MAX
                                                  : dsv_pkg::DM_DIGITS_MAX;
        if (digit_cnt < keep) begin
            case (field_pos)
                dsv_pkg::FIELD_DAY:   day_acc = day_acc * 10 + d;
                dsv_pkg::FIELD_MONTH: month_acc = month_acc * 10 + d;
                default:              year_acc = year_acc * 10 + d;
            endcase
        end
        if (digit_cnt < dsv_pkg::COUNT_SAT)
            digit_cnt = digit_cnt + 1'b1;
        if (digit_cnt > dsv_pkg::YEAR_DIGITS_MAX)
            bad = 1'b1;
    endtask

    task automatic take_char(input logic [7:0] c, input logic last);
        verdict_t v;
        if (!done) begin
            if (c == dsv_pkg::CHAR_SLASH)
                close_field();
            else if (c >= dsv_pkg::CHAR_ZERO && c <= dsv_pkg::CHAR_NINE)
                take_digit(4'(c - dsv_pkg::CHAR_ZERO));
            else
                bad = 1'b1;
        end
        if (last) begin
            // A string that ends inside the year field closes it; earlier is invalid.
            if (!done) begin
                if (field_pos == dsv_pkg::FIELD_YEAR)
                    close_field();
                else
                    bad = 1'b1;
            end
            v.ok = !bad && done &&
                   month_acc >= dsv_pkg::MONTH_FIRST && month_acc <= dsv_pkg::MONTH_LAST &&
                   day_acc >= dsv_pkg::DAY_FIRST &&
                   day_acc <= month_days(month_acc, year_acc);
            v.day   = day_acc;
            v.month = month_acc;
            v.year  = year_acc;
            verdict_q.push_back(v);
            clear_parse();
        end
    endtask

    task automatic check_verdict(input logic [31:0] word);
        verdict_t want;
        if (verdict_q.size() == 0) begin
            $display("%0t: verdict item with none expected, got %h", $time, word);
            fails++;
        end else begin
            want = verdict_q.pop_front();
            if (word[0] !== want.ok) begin
                $display("%0t: date_valid expected %0d got %0d", $time, want.ok, word[0]);
                fails++;
            end
            if (word[7:1] !== want.day) begin
                $display("%0t: day_number expected %0d got %0d", $time, want.day, word[7:1]);
                fails++;
            end
            if (word[14:8] !== want.month) begin
                $display("%0t: month_number expected %0d got %0d", $time, want.month,
                         word[14:8]);
                fails++;
            end
            if (word[28:15] !== want.year) begin
                $display("%0t: year_number expected %0d got %0d", $time, want.year,
                         word[28:15]);
                fails++;
            end
            if (word[31:29] !== 3'b000) begin
                $display("%0t: padding expected 0 got %b", $time, word[31:29]);
                fails++;
            end
        end
    endtask

    // The result side is checked before the byte of the same edge is taken in, so a
    // spurious verdict can never be matched against a verdict predicted in that cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            verdict_q.delete();
            verdicts_pending <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            if (s_tvalid && s_tready)
                take_char(s_tdata, s_tlast);
            verdicts_pending <= verdict_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Top of the date string validator bench: clock, reset, date string stimulus and
// back-pressure on the verdict stream. Depends on dsv_pkg, dsv_checker and the block.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BYTES = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    int          bytes_sent = 0;
    int          cycles = 0;
    logic [7:0]  date_chars[$];

    string directed_dates [21] = '{
        "29/02/2000", "29/02/1900", "29/02/24", "28/2/2023", "31/04/2023", "30/4/99",
        "31/12/9999", "00/01/2020", "1/13/00", "01/00/2020", "123/01/20", "01/001/20",
        "12345/1/20", "01/01/123", "01/01/12345", "9/9/9", "5/5/55/x~", "01/01", "/",
        "01/01/", "0a/01/2020"
    };

    always #4 aclk = ~aclk;

    date_string_validator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dsv_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fail_count       (errors),
        .verdicts_pending (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Verdict side: random stalls, plus one long hold-off each time the request flips.
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_date();
        for (int i = 0; i < date_chars.size(); i++)
            send_char(date_chars[i], i == date_chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        date_chars.delete();
        for (int i = 0; i < s.len(); i++)
            date_chars.push_back(s[i]);
        send_date();
    endtask

    // Appends the low 'count' decimal digits of value, leading zeros included.
    task automatic push_digits(input int unsigned value, input int count);
        int unsigned scale;
        scale = 1;
        for (int i = 1; i < count; i++)
            scale = scale * 10;
        for (int i = 0; i < count; i++) begin
            date_chars.push_back(8'(dsv_pkg::CHAR_ZERO + (value / scale) % 10));
            scale = scale / 10;
        end
    endtask

    function automatic int odd_digits();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 3;
            2:       return 5;
            default: return 8;
        endcase
    endfunction

    task automatic build_random_date();
        int day_dig;
        int month_dig;
        int year_dig;
        int day_val;
        int month_val;
        int unsigned year_val;
        int r;
        int cut;
        date_chars.delete();
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 8))
                date_chars.push_back(8'($urandom_range(255)));
            return;
        end
        day_dig   = ($urandom_range(99) < 90) ? $urandom_range(1, 2) : odd_digits();
        month_dig = ($urandom_range(99) < 90) ? $urandom_range(1, 2) : odd_digits();
        r = $urandom_range(99);
        year_dig = (r < 45) ? 4 : (r < 85) ? 2 : odd_digits();

        // Days are biased toward the month ends so the calendar check gets exercised.
        r = $urandom_range(99);
        day_val = (r < 60) ? $urandom_range(1, 31) :
                  (r < 85) ? $urandom_range(27, 31) : $urandom_range(0, 99);
        month_val = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        if (year_dig == 4) begin
            case ($urandom_range(4))
                0:       year_val = 1900 + 100 * $urandom_range(0, 5);
                1:       year_val = 4 * $urandom_range(0, 2499);
                default: year_val = $urandom_range(0, 9999);
            endcase
        end else begin
            year_val = $urandom;
        end

        push_digits(day_val, day_dig);
        date_chars.push_back(dsv_pkg::CHAR_SLASH);
        push_digits(month_val, month_dig);
        date_chars.push_back(dsv_pkg::CHAR_SLASH);
        push_digits(year_val, year_dig);

        r = $urandom_range(99);
        if (r < 12) begin
            date_chars.push_back(dsv_pkg::CHAR_SLASH);
            repeat ($urandom_range(0, 3))
                date_chars.push_back(8'($urandom_range(255)));
        end else if (r < 20) begin
            cut = $urandom_range(1, date_chars.size());
            date_chars = date_chars[0:cut-1];
        end
        if ($urandom_range(99) < 8)
            date_chars[$urandom_range(0, date_chars.size() - 1)] = 8'($urandom_range(255));
    endtask

    task automatic drain_verdicts();
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_dates[i])
            send_text(directed_dates[i]);
        // Control bytes in the day field, the top bit set in the year field.
        send_text("01/01/2000");
        date_chars[1] = 8'h00;
        send_date();
        date_chars[7] = 8'hFF;
        date_chars[1] = 8'(dsv_pkg::CHAR_ZERO + 1);
        send_date();
        send_text("1/1/2020/");
        date_chars.push_back(8'h80);
        send_date();

        for (int phase = 0; phase < 4; phase++) begin
            s_tvalid <= 1'b0;
            drain_verdicts();
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            // Early in the unthrottled phase the verdict side stops for a while,
            // so final bytes back up behind unread verdicts.
            if (phase == 0)
                hold_req <= ~hold_req;
            target = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < target) begin
                build_random_date();
                send_date();
            end
        end

        s_tvalid <= 1'b0;
        drain_verdicts();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
